// ----- rtl/fei_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fei_pkg: shared definitions of the fractal escape-time iterator
// Fixed-point formats, saturation helpers, queue entry layout, multiplier
// request/response records and the back-end sequencer states.
// ----------------------------------------------------------------------------
package fei_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 17;
  localparam int IN_W        = 32;
  localparam int IN_FRAC     = 28;
  localparam int ZW          = 40;
  localparam int OUT_W       = 16;
  localparam int unsigned LIMIT_CAP = 65536;

  localparam int CAP_W      = $clog2(LIMIT_CAP + 1);
  localparam int LIM_CMP_W  = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;

  // Multiplier is built from half-width partial products.
  localparam int HALF   = (ZW + 1) / 2;
  localparam int PROD_W = 4 * HALF;

  localparam int CONV_SHL = (FRAC_BITS >= IN_FRAC) ? (FRAC_BITS - IN_FRAC) : 0;
  localparam int CONV_SHR = (FRAC_BITS < IN_FRAC) ? (IN_FRAC - FRAC_BITS) : 0;
  localparam int SAT_W    = ((IN_W + CONV_SHL + 1) > (ZW + 2)) ? (IN_W + CONV_SHL + 1)
                                                                 : (ZW + 2);

  // Escape when |z|^2 > 4, i.e. the exact square sum exceeds 2^(2F+2).
  localparam int ESC_POS = 2 * FRAC_BITS + 2;
  localparam int SUM_W   = ((PROD_W + 1) > (ESC_POS + 2)) ? (PROD_W + 1) : (ESC_POS + 2);
  localparam logic [SUM_W-1:0] ESC_THRESH = SUM_W'(1) << ESC_POS;

  localparam logic signed [ZW-1:0] Z_MAX = {1'b0, {(ZW-1){1'b1}}};
  localparam logic signed [ZW-1:0] Z_MIN = {1'b1, {(ZW-1){1'b0}}};

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER = 1'b0,
    CFG_DEGREE   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ZW-1:0]    pr;
    logic signed [ZW-1:0]    pi;
    logic [COUNT_WIDTH-1:0]  limit;
    logic                    mode;
    logic                    no_iter;
  } fei_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic                 start;
    logic signed [ZW-1:0] a;
    logic signed [ZW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic [PROD_W-1:0]    prod;
    logic signed [ZW-1:0] res;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_X_GO,
    B_X_WAIT,
    B_Y_GO,
    B_Y_WAIT,
    B_TEST,
    B_PREP,
    B_P_GO,
    B_P_WAIT,
    B_Q_GO,
    B_Q_WAIT,
    B_UPDATE,
    B_DONE
  } back_state_t;

  // Clamp a wide signed value to the signed ZW-bit range.
  function automatic logic signed [ZW-1:0] sat_z(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(Z_MAX);
    lo = SAT_W'(Z_MIN);
    if (v > hi) begin
      sat_z = Z_MAX;
    end else if (v < lo) begin
      sat_z = Z_MIN;
    end else begin
      sat_z = $signed(v[ZW-1:0]);
    end
  endfunction

  // Magnitude of a signed ZW-bit value; the most negative value fits unsigned.
  function automatic logic [ZW-1:0] mag_z(input logic signed [ZW-1:0] v);
    if (v[ZW-1]) begin
      mag_z = (~v) + ZW'(1);
    end else begin
      mag_z = v;
    end
  endfunction

  // Input point format to internal format; a right shift floors.
  function automatic logic signed [ZW-1:0] to_fixed(input logic signed [IN_W-1:0] c);
    logic signed [SAT_W-1:0] w;
    w = SAT_W'(c);
    w = w <<< CONV_SHL;
    w = w >>> CONV_SHR;
    to_fixed = sat_z(w);
  endfunction

endpackage

// ----- rtl/fei_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fei_front: input acceptance and classification
// Holds the configuration registers, converts each point to the internal
// format, caps the iteration limit and marks points that need no iteration.
// ----------------------------------------------------------------------------
module fei_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [fei_pkg::IN_W-1:0]       in_c_real,
  input  logic signed [fei_pkg::IN_W-1:0]       in_c_imag,
  input  logic                                  cfg_we,
  input  logic [fei_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fei_pkg::COUNT_WIDTH-1:0]       cfg_wdata,
  input  fei_pkg::q_status_t                    q_stat,
  output logic                                  push,
  output fei_pkg::fei_item_t                    item
);

  localparam int CW = fei_pkg::COUNT_WIDTH;
  localparam int LW = fei_pkg::LIM_CMP_W;

  logic [CW-1:0] max_iter_r;
  logic [CW-1:0] max_iter_nxt;
  logic          degree_r;
  logic          degree_nxt;
  logic [CW-1:0] limit;

  always_comb begin
    max_iter_nxt = max_iter_r;
    degree_nxt   = degree_r;
    if (cfg_we) begin
      case (fei_pkg::cfg_reg_t'(cfg_index))
        fei_pkg::CFG_MAX_ITER: begin
          max_iter_nxt = cfg_wdata;
        end
        fei_pkg::CFG_DEGREE: begin
          degree_nxt = cfg_wdata[0];
        end
        default: begin
          max_iter_nxt = max_iter_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= CW'(fei_pkg::LIMIT_CAP);
      degree_r   <= 1'b0;
    end else begin
      max_iter_r <= max_iter_nxt;
      degree_r   <= degree_nxt;
    end
  end

  // Counts never go past the cap, so the result always fits the output field.
  assign limit = (LW'(max_iter_r) > LW'(fei_pkg::LIMIT_CAP)) ? CW'(fei_pkg::LIMIT_CAP)
                                                              : max_iter_r;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    item.pr      = fei_pkg::to_fixed(in_c_real);
    item.pi      = fei_pkg::to_fixed(in_c_imag);
    item.limit   = limit;
    item.mode    = degree_r;
    item.no_iter = (limit <= CW'(1));
  end

endmodule

// ----- rtl/fei_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fei_queue: short queue between front and back end
// A small circular buffer of classified points with full and empty flags.
// ----------------------------------------------------------------------------
module fei_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fei_pkg::fei_item_t  wr_item,
  input  logic                pop,
  output fei_pkg::fei_item_t  rd_item,
  output fei_pkg::q_status_t  q_stat
);

  localparam int PW = fei_pkg::QPTR_W;
  localparam int NW = fei_pkg::QCNT_W;

  fei_pkg::fei_item_t entries [fei_pkg::QDEPTH];

  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [NW-1:0] count_r;
  logic [NW-1:0] count_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full  = (count_r == NW'(fei_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_item      = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(fei_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(fei_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + NW'(1);
      2'b01:   count_nxt = count_r - NW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ----- rtl/fei_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fei_mul: sequential fixed-point multiplier
// Forms the exact product of two signed 40-bit values from four half-width
// partial products, one per cycle, then rounds toward minus infinity and
// saturates. The exact magnitude product is also returned.
// ----------------------------------------------------------------------------
module fei_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  fei_pkg::mul_req_t  req,
  output fei_pkg::mul_rsp_t  rsp
);

  localparam int H  = fei_pkg::HALF;
  localparam int PW = fei_pkg::PROD_W;
  localparam int ZW = fei_pkg::ZW;
  localparam int F  = fei_pkg::FRAC_BITS;
  localparam logic [2:0] PP_STEPS  = 3'd4;
  localparam logic [2:0] POST_STEP = 3'd5;

  logic                 busy_r;
  logic [2:0]           step_r;
  logic [2*H-1:0]       am_r;
  logic [2*H-1:0]       bm_r;
  logic                 neg_r;
  logic [2*H-1:0]       pp_r;
  logic [1:0]           pp_sh_r;
  logic                 pp_vld_r;
  logic [PW-1:0]        acc_r;
  logic signed [ZW-1:0] res_r;
  logic                 done_r;

  logic [H-1:0]         a_part;
  logic [H-1:0]         b_part;
  logic [PW-1:0]        pp_shifted;

  // Floor-rounded, saturated fixed-point value of the signed product.
  function automatic logic signed [ZW-1:0] round_sat(input logic [PW-1:0] p,
                                                     input logic neg);
    logic [PW-1:0] q;
    logic          rem;
    q   = p >> F;
    rem = |p[F-1:0];
    if (!neg) begin
      round_sat = (q > PW'(fei_pkg::Z_MAX)) ? fei_pkg::Z_MAX : $signed(q[ZW-1:0]);
    end else begin
      q = q + PW'(rem);
      if (q > (PW'(1) << (ZW - 1))) begin
        round_sat = fei_pkg::Z_MIN;
      end else begin
        round_sat = $signed((~q[ZW-1:0]) + ZW'(1));
      end
    end
  endfunction

  assign a_part = step_r[1] ? am_r[2*H-1:H] : am_r[H-1:0];
  assign b_part = step_r[0] ? bm_r[2*H-1:H] : bm_r[H-1:0];

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_shifted = PW'(pp_r);
      2'd1:    pp_shifted = PW'(pp_r) << H;
      2'd2:    pp_shifted = PW'(pp_r) << (2 * H);
      default: pp_shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      step_r   <= '0;
      pp_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r   <= 1'b0;
      pp_vld_r <= busy_r && (step_r < PP_STEPS);
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == POST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pp_r    <= (2*H)'(a_part) * (2*H)'(b_part);
    pp_sh_r <= {1'b0, step_r[1]} + {1'b0, step_r[0]};
    if (req.start) begin
      am_r  <= (2*H)'(fei_pkg::mag_z(req.a));
      bm_r  <= (2*H)'(fei_pkg::mag_z(req.b));
      neg_r <= req.a[ZW-1] ^ req.b[ZW-1];
      acc_r <= '0;
    end else if (pp_vld_r) begin
      acc_r <= acc_r + pp_shifted;
    end
    if (busy_r && (step_r == POST_STEP)) begin
      res_r <= round_sat(acc_r, neg_r);
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;
  assign rsp.res  = res_r;

endmodule

// ----- rtl/fei_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fei_back: iteration sequencer and result register
// Takes classified points from the queue, runs the escape-time recurrence
// on the shared multiplier and holds each count until it is transferred.
// ----------------------------------------------------------------------------
module fei_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fei_pkg::q_status_t               q_stat,
  input  fei_pkg::fei_item_t               item,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fei_pkg::OUT_W-1:0]        out_escape_count
);

  localparam int ZW  = fei_pkg::ZW;
  localparam int SW  = fei_pkg::SAT_W;
  localparam int CW  = fei_pkg::COUNT_WIDTH;
  localparam int CW1 = fei_pkg::COUNT_WIDTH + 1;
  localparam int SUW = fei_pkg::SUM_W;
  localparam int PW  = fei_pkg::PROD_W;
  localparam int OW  = fei_pkg::OUT_W;

  fei_pkg::back_state_t state_r;
  fei_pkg::back_state_t state_nxt;
  fei_pkg::mul_req_t    mul_req;
  fei_pkg::mul_rsp_t    mul_rsp;

  logic signed [ZW-1:0] zr_r;
  logic signed [ZW-1:0] zi_r;
  logic signed [ZW-1:0] pr_r;
  logic signed [ZW-1:0] pi_r;
  logic [CW-1:0]        limit_r;
  logic                 mode_r;
  logic [CW-1:0]        iter_r;
  logic [PW-1:0]        xx_r;
  logic [PW-1:0]        yy_r;
  logic signed [ZW-1:0] x2_r;
  logic signed [ZW-1:0] y2_r;
  logic signed [ZW-1:0] x3_r;
  logic signed [ZW-1:0] y3_r;
  logic signed [ZW-1:0] dx_r;
  logic signed [ZW-1:0] dy_r;
  logic signed [ZW-1:0] t_r;
  logic signed [ZW-1:0] u_r;
  logic [OW-1:0]        result_r;
  logic                 out_valid_r;
  logic [OW-1:0]        out_count_r;

  logic [SUW-1:0]       sum_sq;
  logic                 escape;
  logic [CW1-1:0]       iter_inc;
  logic                 hit;
  logic                 stop;
  logic                 can_load_out;
  logic                 out_load;
  logic signed [ZW-1:0] nx;
  logic signed [ZW-1:0] ny;

  fei_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // xx_r and yy_r hold the exact squares of the current z.
  assign sum_sq       = SUW'(xx_r) + SUW'(yy_r);
  assign escape       = sum_sq > fei_pkg::ESC_THRESH;
  assign iter_inc     = CW1'(iter_r) + CW1'(1);
  assign hit          = (iter_r != '0) && escape;
  assign stop         = hit || (iter_inc >= CW1'(limit_r));
  assign can_load_out = !out_valid_r || !out_stall;

  always_comb begin
    if (mode_r) begin
      nx = fei_pkg::sat_z(SW'(t_r) + SW'(pr_r));
      ny = fei_pkg::sat_z(SW'(u_r) + SW'(pi_r));
    end else begin
      nx = fei_pkg::sat_z(SW'(x2_r) - SW'(y2_r) + SW'(pr_r));
      ny = fei_pkg::sat_z(SW'(t_r) + SW'(pi_r));
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fei_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = item.no_iter ? fei_pkg::B_DONE : fei_pkg::B_X_GO;
        end
      end
      fei_pkg::B_X_GO:   state_nxt = fei_pkg::B_X_WAIT;
      fei_pkg::B_X_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = fei_pkg::B_Y_GO;
        end
      end
      fei_pkg::B_Y_GO:   state_nxt = fei_pkg::B_Y_WAIT;
      fei_pkg::B_Y_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = fei_pkg::B_TEST;
        end
      end
      fei_pkg::B_TEST: begin
        if (stop) begin
          state_nxt = fei_pkg::B_DONE;
        end else begin
          state_nxt = mode_r ? fei_pkg::B_PREP : fei_pkg::B_P_GO;
        end
      end
      fei_pkg::B_PREP:   state_nxt = fei_pkg::B_P_GO;
      fei_pkg::B_P_GO:   state_nxt = fei_pkg::B_P_WAIT;
      fei_pkg::B_P_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = mode_r ? fei_pkg::B_Q_GO : fei_pkg::B_UPDATE;
        end
      end
      fei_pkg::B_Q_GO:   state_nxt = fei_pkg::B_Q_WAIT;
      fei_pkg::B_Q_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = fei_pkg::B_UPDATE;
        end
      end
      fei_pkg::B_UPDATE: state_nxt = fei_pkg::B_X_GO;
      fei_pkg::B_DONE: begin
        if (can_load_out) begin
          state_nxt = fei_pkg::B_IDLE;
        end
      end
      default:           state_nxt = fei_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    out_load      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = zr_r;
    mul_req.b     = zr_r;
    case (state_r)
      fei_pkg::B_IDLE: begin
        pop = !q_stat.empty;
      end
      fei_pkg::B_X_GO: begin
        mul_req.start = 1'b1;
      end
      fei_pkg::B_Y_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = zi_r;
        mul_req.b     = zi_r;
      end
      fei_pkg::B_P_GO: begin
        mul_req.start = 1'b1;
        mul_req.b     = mode_r ? dx_r : zi_r;
      end
      fei_pkg::B_Q_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = zi_r;
        mul_req.b     = dy_r;
      end
      fei_pkg::B_DONE: begin
        out_load = can_load_out;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fei_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= result_r;
    end
    case (state_r)
      fei_pkg::B_IDLE: begin
        if (pop) begin
          pr_r     <= item.pr;
          pi_r     <= item.pi;
          limit_r  <= item.limit;
          mode_r   <= item.mode;
          zr_r     <= '0;
          zi_r     <= '0;
          iter_r   <= '0;
          result_r <= '0;
        end
      end
      fei_pkg::B_X_WAIT: begin
        if (mul_rsp.done) begin
          x2_r <= mul_rsp.res;
          xx_r <= mul_rsp.prod;
        end
      end
      fei_pkg::B_Y_WAIT: begin
        if (mul_rsp.done) begin
          y2_r <= mul_rsp.res;
          yy_r <= mul_rsp.prod;
        end
      end
      fei_pkg::B_TEST: begin
        // Squares are never negative, so tripling is a clamp at the top only.
        x3_r     <= fei_pkg::sat_z((SW'(x2_r) <<< 1) + SW'(x2_r));
        y3_r     <= fei_pkg::sat_z((SW'(y2_r) <<< 1) + SW'(y2_r));
        result_r <= hit ? OW'(iter_r) : '0;
      end
      fei_pkg::B_PREP: begin
        dx_r <= x2_r - y3_r;
        dy_r <= x3_r - y2_r;
      end
      fei_pkg::B_P_WAIT: begin
        if (mul_rsp.done) begin
          t_r <= mode_r ? mul_rsp.res : fei_pkg::sat_z(SW'($signed(mul_rsp.res)) <<< 1);
        end
      end
      fei_pkg::B_Q_WAIT: begin
        if (mul_rsp.done) begin
          u_r <= mul_rsp.res;
        end
      end
      fei_pkg::B_UPDATE: begin
        zr_r   <= nx;
        zi_r   <= ny;
        iter_r <= iter_r + CW'(1);
      end
      default: begin
        result_r <= result_r;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_escape_count = out_count_r;

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_count_r == $past(out_count_r)))
    else $error("pending result overwritten");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == fei_pkg::B_X_WAIT || state_r == fei_pkg::B_Y_WAIT ||
                      state_r == fei_pkg::B_P_WAIT || state_r == fei_pkg::B_Q_WAIT))
    else $error("multiplier finished outside a wait state");

  a_test_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fei_pkg::B_TEST) |-> (CW1'(iter_r) < CW1'(limit_r)))
    else $error("iteration count reached the limit");

endmodule

// ----- rtl/fractal_escape_time_iterator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_escape_time_iterator: escape-time count of a complex point
// Iterates z = z^2 + c or z = z^3 + c from zero and reports the first
// iteration at which |z|^2 exceeds 4, or zero when the limit runs out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one point c as two signed
//   Q4.28 words. A transfer happens on a rising edge with valid high and
//   stall low. Output channel (out_valid / out_stall) carries one 16-bit
//   escape count per point, in input order.
//   The configuration port writes the iteration limit (index 0) or the degree
//   mode (index 1) whenever cfg_we is high; write only while the block is idle.
//   The back end works on one point until its count is loaded, so a new
//   point starts only after the last one is through. Each iteration runs
//   three (squared) or four (cubic) 40x40 products through one shared
//   multiplier that forms a half-width partial product per cycle. Points
//   whose limit is 0 or 1 skip the iteration and go straight to the result.
//   A two-entry queue lets the front accept points while the back end works,
//   and a result register holds each count while the receiver stalls; the
//   back end waits in its final state until that register is free.
//   Reset (rst_n low, synchronous) empties the queue and the result register,
//   returns the sequencer to idle and restores the limit 65536, squared mode.
// ----------------------------------------------------------------------------
module fractal_escape_time_iterator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fei_pkg::IN_W-1:0]     in_c_real,
  input  logic signed [fei_pkg::IN_W-1:0]     in_c_imag,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fei_pkg::OUT_W-1:0]           out_escape_count,
  input  logic                                cfg_we,
  input  logic [fei_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fei_pkg::COUNT_WIDTH-1:0]     cfg_wdata
);

  // Front to queue: a classified point and its write strobe.
  fei_pkg::fei_item_t push_item;
  logic               push;

  // Queue to back end: the oldest point, its status and the pop strobe.
  fei_pkg::fei_item_t head_item;
  fei_pkg::q_status_t q_stat;
  logic               pop;

  // The front owns the configuration registers and the input transfer; it
  // stalls the input only when the queue is full.
  fei_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_c_real (in_c_real),
    .in_c_imag (in_c_imag),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .item      (push_item)
  );

  fei_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (push_item),
    .pop     (pop),
    .rd_item (head_item),
    .q_stat  (q_stat)
  );

  // The back end works on one point at a time and owns the result register.
  fei_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .item             (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_escape_count (out_escape_count)
  );

endmodule
